FILE: hw/rtl/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

   localparam int DATA_W = 32;
   localparam int NUM_W  = 31;
   localparam int CNT_W  = $clog2(DATA_W);

   typedef logic [2:0]              action_type;
   typedef logic [2:0]              status_type;
   typedef logic [NUM_W-1:0]        number_type;
   typedef logic signed [DATA_W-1:0] value_type;
   typedef logic [1:0]              alu_op_type;

   localparam action_type ACT_PUSH   = 3'd0;
   localparam action_type ACT_ADD    = 3'd1;
   localparam action_type ACT_SUB    = 3'd2;
   localparam action_type ACT_MUL    = 3'd3;
   localparam action_type ACT_DIV    = 3'd4;
   localparam action_type ACT_FINISH = 3'd5;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_UNDERFLOW = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_DIVZERO   = 3'd3;
   localparam status_type ST_HALTED    = 3'd4;

   localparam alu_op_type ALU_ADD = 2'd0;
   localparam alu_op_type ALU_SUB = 2'd1;
   localparam alu_op_type ALU_MUL = 2'd2;
   localparam alu_op_type ALU_DIV = 2'd3;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

endpackage

FILE: hw/rtl/rpn_req_if.sv
`timescale 1ns / 1ps

interface rpn_req_if;
   logic                valid;
   logic                ready;
   rpn_pkg::action_type action;
   rpn_pkg::number_type number;

   modport source (output valid, action, number, input ready);
   modport sink (input valid, action, number, output ready);
endinterface

FILE: hw/rtl/rpn_rsp_if.sv
`timescale 1ns / 1ps

interface rpn_rsp_if;
   logic                valid;
   logic                ready;
   rpn_pkg::value_type  value;
   rpn_pkg::status_type status;

   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

FILE: hw/rtl/rpn_ram.sv
`timescale 1ns / 1ps

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/rpn_alu.sv
`timescale 1ns / 1ps

module rpn_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  rpn_pkg::alu_cmd_type        cmd,
   input  logic [rpn_pkg::DATA_W-1:0]  left,
   input  logic [rpn_pkg::DATA_W-1:0]  right,
   output rpn_pkg::alu_sts_type        sts,
   output logic [rpn_pkg::DATA_W-1:0]  result
);
   import rpn_pkg::*;

   localparam logic [1:0] A_IDLE = 2'd0;
   localparam logic [1:0] A_PRE  = 2'd1;
   localparam logic [1:0] A_RUN  = 2'd2;
   localparam logic [1:0] A_POST = 2'd3;

   logic [1:0]        state_ff, state_in;
   alu_op_type        op_ff, op_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              carry_ff, carry_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;

   logic              b_bit;
   logic              sum_bit;
   logic              carry_out;
   logic [DATA_W-1:0] rem_shift;
   logic [DATA_W:0]   rem_diff;

   // Add and subtract run one bit per cycle, least significant first; for a
   // subtraction the right operand is inverted and the carry starts at one.
   assign b_bit     = b_ff[0] ^ (op_ff == ALU_SUB);
   assign sum_bit   = a_ff[0] ^ b_bit ^ carry_ff;
   assign carry_out = (a_ff[0] & b_bit) | (a_ff[0] & carry_ff) | (b_bit & carry_ff);

   // Restoring division: the dividend magnitude shifts out of a_ff at the top
   // while quotient bits shift in at the bottom.
   assign rem_shift = {acc_ff[DATA_W-2:0], a_ff[DATA_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {1'b0, b_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               a_in     = left;
               b_in     = right;
               acc_in   = '0;
               cnt_in   = '0;
               carry_in = (cmd.op == ALU_SUB);
               neg_in   = left[DATA_W-1] ^ right[DATA_W-1];
               state_in = A_PRE;
            end
         end
         A_PRE: begin
            if (op_ff == ALU_DIV) begin
               if (a_ff[DATA_W-1]) begin
                  a_in = '0 - a_ff;
               end
               if (b_ff[DATA_W-1]) begin
                  b_in = '0 - b_ff;
               end
            end
            state_in = A_RUN;
         end
         A_RUN: begin
            case (op_ff) inside
               ALU_ADD, ALU_SUB: begin
                  acc_in   = {sum_bit, acc_ff[DATA_W-1:1]};
                  carry_in = carry_out;
                  a_in     = {1'b0, a_ff[DATA_W-1:1]};
                  b_in     = {1'b0, b_ff[DATA_W-1:1]};
               end
               ALU_MUL: begin
                  acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
                  a_in   = {a_ff[DATA_W-2:0], 1'b0};
                  b_in   = {1'b0, b_ff[DATA_W-1:1]};
               end
               default: begin
                  acc_in = rem_diff[DATA_W] ? rem_shift : rem_diff[DATA_W-1:0];
                  a_in   = {a_ff[DATA_W-2:0], ~rem_diff[DATA_W]};
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               state_in = A_POST;
            end
         end
         A_POST: begin
            if (op_ff == ALU_DIV) begin
               res_in = neg_ff ? ('0 - a_ff) : a_ff;
            end else begin
               res_in = acc_ff;
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      cnt_ff   <= cnt_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   assign sts    = '{busy: (state_ff != A_IDLE), done: done_ff};
   assign result = res_ff;

endmodule

FILE: hw/rtl/rpn_stack_calculator.sv
// Each word passes through the states in order: push, ignored code, underflow or any word
// while halted go straight to the answer; finish reads the top first; a zero divisor reads
// both operands first; add, subtract, multiply and divide also run the bit-serial unit.
// Throughput: one word at a time; the next word is taken once the answer is registered.
// Reset (synchronous, active high) empties the stack and clears the halt; stack memory
// is not cleared, as an entry is only read after it has been written.
`timescale 1ns / 1ps

module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   rpn_req_if.sink    req_bus,
   rpn_rsp_if.source  rsp_bus
);
   import rpn_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] TWO_COUNT  = CW'(2);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ_R = 3'd1;
   localparam logic [2:0] S_READ_L = 3'd2;
   localparam logic [2:0] S_READ_F = 3'd3;
   localparam logic [2:0] S_EXEC   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              halted_ff, halted_in;
   action_type        action_ff, action_in;
   logic [DATA_W-1:0] right_ff, right_in;
   value_type         pend_value_ff, pend_value_in;
   status_type        pend_status_ff, pend_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic [CW-1:0]     count_m1;
   logic [CW-1:0]     count_m2;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [DATA_W-1:0] ram_rdata;
   alu_op_type        alu_op;
   alu_cmd_type       alu_cmd;
   alu_sts_type       alu_sts;
   logic [DATA_W-1:0] alu_result;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign count_m1      = count_ff - 1'b1;
   assign count_m2      = count_ff - TWO_COUNT;

   rpn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rpn_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .left   (ram_rdata),
      .right  (right_ff),
      .sts    (alu_sts),
      .result (alu_result)
   );

   always_comb begin
      unique case (action_ff)
         ACT_ADD: alu_op = ALU_ADD;
         ACT_SUB: alu_op = ALU_SUB;
         ACT_MUL: alu_op = ALU_MUL;
         default: alu_op = ALU_DIV;
      endcase
   end

   // The top of the stack is read while idle so that it is ready in the
   // following cycle; the entry beneath it is read in S_READ_R.
   always_comb begin
      if (state_ff == S_READ_R) begin
         ram_raddr = count_m2[AW-1:0];
      end else begin
         ram_raddr = count_m1[AW-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      halted_in      = halted_ff;
      action_in      = action_ff;
      right_in       = right_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      ram_we         = 1'b0;
      ram_waddr      = count_m2[AW-1:0];
      ram_wdata      = alu_result;
      alu_cmd.start  = 1'b0;
      alu_cmd.op     = alu_op;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in      = req_bus.action;
               pend_value_in  = '0;
               pend_status_in = ST_OK;
               state_in       = S_RESP;
               if (halted_ff) begin
                  pend_status_in = ST_HALTED;
               end else begin
                  case (req_bus.action) inside
                     ACT_PUSH: begin
                        if (count_ff < FULL_COUNT) begin
                           ram_we    = 1'b1;
                           ram_waddr = count_ff[AW-1:0];
                           ram_wdata = {1'b0, req_bus.number};
                           count_in  = count_ff + 1'b1;
                        end else begin
                           pend_status_in = ST_FULL;
                        end
                     end
                     ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                        if (count_ff < TWO_COUNT) begin
                           pend_status_in = ST_UNDERFLOW;
                           halted_in      = 1'b1;
                        end else begin
                           state_in = S_READ_R;
                        end
                     end
                     ACT_FINISH: begin
                        halted_in = 1'b1;
                        if (count_ff == '0) begin
                           pend_status_in = ST_UNDERFLOW;
                        end else begin
                           state_in = S_READ_F;
                        end
                     end
                     default: begin
                        // Unused codes leave the state alone and answer ok.
                     end
                  endcase
               end
            end
         end
         S_READ_R: begin
            right_in = ram_rdata;
            state_in = S_READ_L;
         end
         S_READ_L: begin
            if ((action_ff == ACT_DIV) && (right_ff == '0)) begin
               pend_status_in = ST_DIVZERO;
               halted_in      = 1'b1;
               state_in       = S_RESP;
            end else begin
               alu_cmd.start = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_READ_F: begin
            pend_value_in = $signed(ram_rdata);
            count_in      = count_m1;
            state_in      = S_RESP;
         end
         S_EXEC: begin
            if (alu_sts.done) begin
               ram_we        = 1'b1;
               count_in      = count_m1;
               pend_value_in = $signed(alu_result);
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff      <= action_in;
      right_ff       <= right_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("stack count exceeds the stack depth");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   a_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !ram_we)
      else $error("stack written while halted");

   a_alu_in_exec: assert property (@(posedge clock) disable iff (reset)
      (alu_sts.busy || alu_sts.done) |-> (state_ff == S_EXEC))
      else $error("arithmetic unit active outside execution");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !halted_ff && (req_bus.action == ACT_PUSH) && (count_ff < FULL_COUNT))
      |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("push did not grow the stack");

endmodule

FILE: test/rpn_stack_calculator_tb.sv
`timescale 1ns / 1ps

module rpn_stack_calculator_tb;
   import rpn_pkg::*;

   localparam int STACK_DEPTH   = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 50;
   localparam int PRINT_LIMIT   = 40;

   // Codes 6 and 7 are not actions; the block answers them and leaves the stack alone.
   localparam action_type ACT_SPARE_6 = 3'd6;
   localparam action_type ACT_SPARE_7 = 3'd7;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_type;

   typedef struct {
      value_type  value;
      status_type status;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   rpn_req_if req_bus ();
   rpn_rsp_if rsp_bus ();

   rpn_stack_calculator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the operand stack, updated as each word is accepted.
   logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
   int                calc_depth;
   bit                calc_halted;
   answer_type        expected_answers [$];

   int           mismatch_count;
   int           answers_seen;
   int           burst_left;
   int           burst_max;
   int           gap_max;
   bit           offering;
   rx_style_type rx_style;
   logic [7:0]   rx_pattern;
   int           hold_request;
   int           hold_left;

   function automatic answer_type stack_apply(action_type act, number_type num);
      answer_type        ans;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] lmag;
      logic [DATA_W-1:0] rmag;
      bit                ok;
      ans.value  = '0;
      ans.status = ST_OK;
      if (calc_halted) begin
         ans.status = ST_HALTED;
      end else begin
         case (act)
            ACT_PUSH: begin
               if (calc_depth < STACK_DEPTH) begin
                  calc_stack[calc_depth] = {1'b0, num};
                  calc_depth++;
               end else begin
                  ans.status = ST_FULL;
               end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
               if (calc_depth < 2) begin
                  ans.status  = ST_UNDERFLOW;
                  calc_halted = 1'b1;
               end else begin
                  rhs = calc_stack[calc_depth-1];
                  lhs = calc_stack[calc_depth-2];
                  ok  = 1'b1;
                  res = '0;
                  case (act)
                     ACT_ADD: res = lhs + rhs;
                     ACT_SUB: res = lhs - rhs;
                     ACT_MUL: res = lhs * rhs;
                     default: begin
                        if (rhs == '0) begin
                           ok = 1'b0;
                        end else begin
                           // Divide the magnitudes so that the quotient truncates
                           // toward zero and the most negative case wraps.
                           lmag = lhs[DATA_W-1] ? -lhs : lhs;
                           rmag = rhs[DATA_W-1] ? -rhs : rhs;
                           res  = lmag / rmag;
                           if (lhs[DATA_W-1] != rhs[DATA_W-1]) res = -res;
                        end
                     end
                  endcase
                  if (ok) begin
                     calc_depth--;
                     calc_stack[calc_depth-1] = res;
                     ans.value = res;
                  end else begin
                     ans.status  = ST_DIVZERO;
                     calc_halted = 1'b1;
                  end
               end
            end
            ACT_FINISH: begin
               if (calc_depth == 0) begin
                  ans.status = ST_UNDERFLOW;
               end else begin
                  calc_depth--;
                  ans.value = calc_stack[calc_depth];
               end
               calc_halted = 1'b1;
            end
            default: ;
         endcase
      end
      return ans;
   endfunction

   function automatic number_type pick_number();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return number_type'(1) << $urandom_range(0, NUM_W-1);
         3, 4, 5: return number_type'($urandom_range(0, 15));
         default: return number_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("answer %0d: %s, got %h, expected %h", answers_seen, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen++;
         if (expected_answers.size() == 0) begin
            report_mismatch("answer with no word outstanding", rsp_bus.value, '0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_bus.value !== want.value)
               report_mismatch("value", rsp_bus.value, want.value);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         case (rx_style)
            RX_ALWAYS: rsp_bus.ready <= 1'b1;
            RX_RANDOM: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_bus.ready <= rx_pattern[0];
               rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            end
         endcase
      end
   end

   // Called at a rising edge; returns at the edge where the word was taken or after its gap.
   task automatic send_word(action_type act, number_type num);
      int gap;
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.number <= num;
      offering = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      expected_answers.push_back(stack_apply(act, num));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, burst_max);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_answers();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed: no arithmetic below two entries and no zero divisor.
   task automatic send_random_item(int push_pct);
      int         r;
      action_type act;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
      end else if (calc_depth < 2 || r < push_pct) begin
         act = ACT_PUSH;
      end else begin
         case ($urandom_range(0, 3))
            0: act = ACT_ADD;
            1: act = ACT_SUB;
            2: act = ACT_MUL;
            default: act = ACT_DIV;
         endcase
         if (act == ACT_DIV && calc_stack[calc_depth-1] == '0) act = ACT_SUB;
      end
      send_word(act, pick_number());
   endtask

   task automatic test_directed_arith();
      rx_style  = RX_ALWAYS;
      gap_max   = 0;
      burst_max = 0;
      send_word(ACT_PUSH, '1);
      send_word(ACT_PUSH, 31'd1);
      send_word(ACT_ADD, '0);           // wraps to the most negative number
      send_word(ACT_PUSH, '0);
      send_word(ACT_PUSH, 31'd1);
      send_word(ACT_SUB, '1);           // minus one
      send_word(ACT_DIV, '0);           // most negative over minus one wraps
      send_word(ACT_PUSH, 31'd7);
      send_word(ACT_MUL, '1);
      send_word(ACT_PUSH, 31'd2);
      send_word(ACT_DIV, '0);
      send_word(ACT_SPARE_6, '1);
      send_word(ACT_SPARE_7, '0);
      send_word(ACT_PUSH, 31'd3);
      send_word(ACT_PUSH, 31'd10);
      send_word(ACT_SUB, '0);
      send_word(ACT_PUSH, 31'd2);
      send_word(ACT_DIV, '1);           // minus seven over two truncates to minus three
      send_word(ACT_MUL, '0);
      wait_for_answers();
   endtask

   task automatic test_full_stack();
      rx_style   = RX_PATTERN;
      rx_pattern = 8'b1011_0110;
      gap_max    = 3;
      burst_max  = 4;
      while (calc_depth < STACK_DEPTH) send_word(ACT_PUSH, pick_number());
      send_word(ACT_PUSH, '1);
      send_word(ACT_PUSH, pick_number());
      wait_for_answers();
   endtask

   task automatic test_receiver_hold();
      rx_style     = RX_RANDOM;
      gap_max      = 0;
      hold_request = HOLD_CYCLES;
      repeat (25) send_random_item(50);
      wait_for_answers();
   endtask

   task automatic test_random_mix();
      int push_pct;
      for (int episode = 0; episode < 20; episode++) begin
         push_pct = $urandom_range(25, 85);
         case ($urandom_range(0, 2))
            0: rx_style = RX_ALWAYS;
            1: rx_style = RX_RANDOM;
            default: rx_style = RX_PATTERN;
         endcase
         rx_pattern = 8'($urandom) | 8'h11;
         gap_max    = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         burst_max  = $urandom_range(0, 6);
         repeat (20) send_random_item(push_pct);
         if (episode % 4 == 3) wait_for_answers();
      end
      wait_for_answers();
   endtask

   // The halt lasts until reset, so one cause is picked per run and comes last.
   task automatic test_halt();
      rx_style = RX_RANDOM;
      gap_max  = 2;
      case ($urandom_range(0, 2))
         0: begin
            while (calc_depth > 1) send_word(ACT_ADD, pick_number());
            case ($urandom_range(0, 3))
               0: send_word(ACT_ADD, pick_number());
               1: send_word(ACT_SUB, pick_number());
               2: send_word(ACT_MUL, pick_number());
               default: send_word(ACT_DIV, pick_number());
            endcase
         end
         1: begin
            if (calc_depth == 0) send_word(ACT_PUSH, 31'd5);
            if (calc_depth == STACK_DEPTH) send_word(ACT_ADD, '0);
            send_word(ACT_PUSH, '0);
            send_word(ACT_DIV, pick_number());
         end
         default: send_word(ACT_FINISH, pick_number());
      endcase
      for (int a = 0; a < 8; a++) send_word(action_type'(a), pick_number());
      wait_for_answers();
   endtask

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_PUSH;
      req_bus.number = '0;
      rsp_bus.ready  = 1'b0;
      calc_depth     = 0;
      calc_halted    = 1'b0;
      mismatch_count = 0;
      answers_seen   = 0;
      burst_left     = 0;
      burst_max      = 0;
      gap_max        = 0;
      offering       = 1'b0;
      rx_style       = RX_ALWAYS;
      rx_pattern     = 8'hFF;
      hold_request   = 0;
      hold_left      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_arith();
      test_full_stack();
      test_receiver_hold();
      test_random_mix();
      test_halt();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
